// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define WSTR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wstr assertion failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define WSTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wstr assertion failed");

`endif

// ===== rtl/wstr_pkg.sv =====
// Shared types and constants of the WebSocket text reassembler.
package wstr_pkg;

  // Store sizing.
  localparam int unsigned MaxMessageBytes = 4096;
  localparam int unsigned CapW            = $clog2(MaxMessageBytes + 1);
  localparam int unsigned CfgW            = 13;
  localparam int unsigned WrAddrW         = 12;
  localparam int unsigned MsgLenW         = 13;
  localparam int unsigned ControlMaxBytes = 125;

  // Queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration registers.
  localparam int unsigned PAddrW      = 3;
  localparam logic        RegCapacity = 1'b0;
  localparam logic [CfgW-1:0] CapacityReset = CfgW'(4096);

  // Item kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_LIMIT       = 2'd3
  } status_e;

  // One classified word as it travels through the queue.
  typedef struct packed {
    logic        is_hdr;
    logic        is_data;
    logic        is_clear;
    logic [3:0]  op;
    logic        fin;
    logic        op_ctrl;
    logic        op_text;
    logic        op_cont;
    logic        ctrl_bad;
    logic        off_zero;
    logic        clen_zero;
    logic [31:0] frame_len;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [7:0]  data_byte;
  } item_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// ===== rtl/wstr_if.sv =====
// Valid/ready channel interfaces for input words and result words.
interface wstr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  opcode;
  logic        fin;
  logic [31:0] frame_len;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, kind, opcode, fin, frame_len, chunk_offset, chunk_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, opcode, fin, frame_len, chunk_offset, chunk_length, data_byte,
    output ready
  );
endinterface

interface wstr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        write_valid;
  logic [11:0] write_address;
  logic [7:0]  write_data;
  logic        message_done;
  logic [12:0] msg_len;

  modport source (
    output valid, status, write_valid, write_address, write_data, message_done,
           msg_len,
    input  ready
  );
  modport sink (
    input  valid, status, write_valid, write_address, write_data, message_done,
           msg_len,
    output ready
  );
endinterface

// ===== rtl/wstr_front.sv =====
// Front end: accepts input words and classifies them for the back end.
module wstr_front (
  wstr_in_if.sink        in_ch_i,
  input  logic           full_i,
  output logic           push_o,
  output wstr_pkg::item_t item_o
);
  import wstr_pkg::*;

  // Accept whenever the queue has room.
  assign in_ch_i.ready = !full_i;
  assign push_o        = in_ch_i.valid && !full_i;

  // Decode the kind and opcode and run the checks that need no state.
  always_comb begin
    item_o.is_hdr       = (in_ch_i.kind == KIND_HEADER);
    item_o.is_data      = (in_ch_i.kind == KIND_DATA);
    item_o.is_clear     = (in_ch_i.kind == KIND_CLEAR);
    item_o.op           = in_ch_i.opcode;
    item_o.fin          = in_ch_i.fin;
    item_o.op_ctrl      = (in_ch_i.opcode == OP_CLOSE) || (in_ch_i.opcode == OP_PING) ||
                          (in_ch_i.opcode == OP_PONG);
    item_o.op_text      = (in_ch_i.opcode == OP_TEXT);
    item_o.op_cont      = (in_ch_i.opcode == OP_CONT);
    item_o.ctrl_bad     = !in_ch_i.fin ||
                          (in_ch_i.frame_len > 32'(ControlMaxBytes)) ||
                          (in_ch_i.chunk_offset != 32'd0) ||
                          (in_ch_i.chunk_length != in_ch_i.frame_len);
    item_o.off_zero     = (in_ch_i.chunk_offset == 32'd0);
    item_o.clen_zero    = (in_ch_i.chunk_length == 32'd0);
    item_o.frame_len    = in_ch_i.frame_len;
    item_o.chunk_offset = in_ch_i.chunk_offset;
    item_o.chunk_length = in_ch_i.chunk_length;
    item_o.data_byte    = in_ch_i.data_byte;
  end

endmodule

// ===== rtl/wstr_queue.sv =====
// Short queue of classified words between the front and back ends.
module wstr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wstr_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output wstr_pkg::q_head_t head_o
);
  import wstr_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/wstr_back.sv =====
// Back end: message and frame state, the checks against it, and the result register.
module wstr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wstr_pkg::q_head_t          head_i,
  output logic                       pop_o,
  input  logic [wstr_pkg::CfgW-1:0]  capacity_i,
  wstr_out_if.source                 out_ch_o
);
  import wstr_pkg::*;

  // Reassembly state.
  status_e         err_q, err_d;
  logic            msg_active_q, msg_active_d;
  logic            frame_active_q, frame_active_d;
  logic [CapW-1:0] bim_q, bim_d;
  logic [31:0]     total_q, total_d;
  logic [31:0]     prog_q, prog_d;
  logic [31:0]     left_q, left_d;
  logic [3:0]      frame_op_q, frame_op_d;
  logic            frame_final_q, frame_final_d;
  logic [31:0]     chunk_left_q, chunk_left_d;
  logic            chunk_ctrl_q, chunk_ctrl_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  status_e            r_status_q, r_status_d;
  logic               r_write_q, r_write_d;
  logic [WrAddrW-1:0] r_addr_q, r_addr_d;
  logic [7:0]         r_data_q, r_data_d;
  logic               r_done_q, r_done_d;
  logic [MsgLenW-1:0] r_len_q, r_len_d;

  item_t           it;
  logic [CapW-1:0] cap_sat, room, bim_b, bim_inc;
  logic [31:0]     total_b, prog_b, left_b, bim32, len32;
  status_e         hdr_err;

  assign it    = head_i.item;
  assign pop_o = head_i.valid && (!out_valid_q || out_ch_o.ready);

  // Room left in the store, measured from the message start this header implies.
  always_comb begin
    if (32'(capacity_i) > 32'(MaxMessageBytes)) begin
      cap_sat = CapW'(MaxMessageBytes);
    end else begin
      cap_sat = CapW'(capacity_i);
    end
    bim_b   = (it.off_zero && it.op_text) ? '0 : bim_q;
    room    = (cap_sat > bim_b) ? cap_sat - bim_b : '0;
    total_b = it.off_zero ? it.frame_len : total_q;
    prog_b  = it.off_zero ? 32'd0 : prog_q;
    left_b  = it.off_zero ? it.frame_len : left_q;
    bim_inc = bim_q + 1'b1;
  end

  // Header checks in priority order.
  always_comb begin
    hdr_err = ST_OK;
    if (chunk_left_q != 32'd0) begin
      hdr_err = ST_INVALID;
    end else if (it.op_ctrl) begin
      if (it.ctrl_bad) begin
        hdr_err = ST_INVALID;
      end
    end else begin
      if (it.off_zero) begin
        if (frame_active_q) begin
          hdr_err = ST_INVALID;
        end else if (it.op_text) begin
          if (msg_active_q) begin
            hdr_err = ST_INVALID;
          end
        end else if (it.op_cont) begin
          if (!msg_active_q) begin
            hdr_err = ST_INVALID;
          end
        end else begin
          hdr_err = ST_UNSUPPORTED;
        end
      end else if (!frame_active_q || (it.op != frame_op_q) || (it.fin != frame_final_q) ||
                   (it.frame_len != total_q)) begin
        hdr_err = ST_INVALID;
      end
      if (hdr_err == ST_OK) begin
        if ((it.chunk_offset != prog_b) || (it.chunk_length > left_b)) begin
          hdr_err = ST_INVALID;
        end else if (it.chunk_length > 32'(room)) begin
          hdr_err = ST_LIMIT;
        end
      end
    end
  end

  // State update and result for the word at the head of the queue.
  always_comb begin
    err_d          = err_q;
    msg_active_d   = msg_active_q;
    frame_active_d = frame_active_q;
    bim_d          = bim_q;
    total_d        = total_q;
    prog_d         = prog_q;
    left_d         = left_q;
    frame_op_d     = frame_op_q;
    frame_final_d  = frame_final_q;
    chunk_left_d   = chunk_left_q;
    chunk_ctrl_d   = chunk_ctrl_q;
    r_write_d      = 1'b0;
    r_data_d       = 8'd0;
    r_done_d       = 1'b0;
    bim32          = 32'(bim_q);
    len32          = 32'd0;
    r_addr_d       = '0;

    if (pop_o) begin
      if (it.is_clear) begin
        err_d          = ST_OK;
        msg_active_d   = 1'b0;
        frame_active_d = 1'b0;
        bim_d          = '0;
        total_d        = 32'd0;
        prog_d         = 32'd0;
        left_d         = 32'd0;
        frame_op_d     = 4'd0;
        frame_final_d  = 1'b0;
        chunk_left_d   = 32'd0;
        chunk_ctrl_d   = 1'b0;
      end else if (err_q == ST_OK) begin
        if (it.is_hdr) begin
          if (hdr_err != ST_OK) begin
            err_d          = hdr_err;
            msg_active_d   = 1'b0;
            frame_active_d = 1'b0;
            bim_d          = '0;
            total_d        = 32'd0;
            prog_d         = 32'd0;
            left_d         = 32'd0;
            chunk_left_d   = 32'd0;
            chunk_ctrl_d   = 1'b0;
          end else if (it.op_ctrl) begin
            chunk_left_d = it.chunk_length;
            chunk_ctrl_d = 1'b1;
          end else begin
            if (it.off_zero && it.op_text) begin
              msg_active_d = 1'b1;
            end
            if (it.off_zero) begin
              frame_op_d    = it.op;
              frame_final_d = it.fin;
            end
            frame_active_d = 1'b1;
            bim_d          = bim_b;
            total_d        = total_b;
            prog_d         = prog_b + it.chunk_length;
            left_d         = left_b - it.chunk_length;
            chunk_left_d   = it.chunk_length;
            chunk_ctrl_d   = 1'b0;
            // An empty chunk that closes its frame completes right here.
            if (it.clen_zero && (left_b == 32'd0)) begin
              frame_active_d = 1'b0;
              if (it.fin) begin
                r_done_d     = 1'b1;
                len32        = 32'(bim_b);
                msg_active_d = 1'b0;
                bim_d        = '0;
                total_d      = 32'd0;
                prog_d       = 32'd0;
                left_d       = 32'd0;
              end
            end
          end
        end else if (it.is_data) begin
          if (chunk_left_q == 32'd0) begin
            // Stray data byte.
            err_d          = ST_INVALID;
            msg_active_d   = 1'b0;
            frame_active_d = 1'b0;
            bim_d          = '0;
            total_d        = 32'd0;
            prog_d         = 32'd0;
            left_d         = 32'd0;
            chunk_left_d   = 32'd0;
            chunk_ctrl_d   = 1'b0;
          end else begin
            chunk_left_d = chunk_left_q - 32'd1;
            if (!chunk_ctrl_q) begin
              r_write_d = 1'b1;
              r_addr_d  = bim32[WrAddrW-1:0];
              r_data_d  = it.data_byte;
              bim_d     = bim_inc;
              // Last byte of the chunk that also ends the frame.
              if ((chunk_left_q == 32'd1) && (left_q == 32'd0)) begin
                frame_active_d = 1'b0;
                if (frame_final_q) begin
                  r_done_d     = 1'b1;
                  len32        = 32'(bim_inc);
                  msg_active_d = 1'b0;
                  bim_d        = '0;
                  total_d      = 32'd0;
                  prog_d       = 32'd0;
                  left_d       = 32'd0;
                end
              end
            end
          end
        end
      end
    end

    r_status_d = err_d;
    r_len_d    = len32[MsgLenW-1:0];
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q          <= ST_OK;
      msg_active_q   <= 1'b0;
      frame_active_q <= 1'b0;
      bim_q          <= '0;
      total_q        <= 32'd0;
      prog_q         <= 32'd0;
      left_q         <= 32'd0;
      frame_op_q     <= 4'd0;
      frame_final_q  <= 1'b0;
      chunk_left_q   <= 32'd0;
      chunk_ctrl_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      err_q          <= err_d;
      msg_active_q   <= msg_active_d;
      frame_active_q <= frame_active_d;
      bim_q          <= bim_d;
      total_q        <= total_d;
      prog_q         <= prog_d;
      left_q         <= left_d;
      frame_op_q     <= frame_op_d;
      frame_final_q  <= frame_final_d;
      chunk_left_q   <= chunk_left_d;
      chunk_ctrl_q   <= chunk_ctrl_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result payload loads only when a word is taken from the queue.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      r_status_q <= r_status_d;
      r_write_q  <= r_write_d;
      r_addr_q   <= r_addr_d;
      r_data_q   <= r_data_d;
      r_done_q   <= r_done_d;
      r_len_q    <= r_len_d;
    end
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.status        = r_status_q;
  assign out_ch_o.write_valid   = r_write_q;
  assign out_ch_o.write_address = r_addr_q;
  assign out_ch_o.write_data    = r_data_q;
  assign out_ch_o.message_done  = r_done_q;
  assign out_ch_o.msg_len       = r_len_q;

endmodule

// ===== rtl/websocket_text_reassembler.sv =====
// Top level of the WebSocket text reassembler: front end, queue, back end, config port.
//
//   Channel    Dir  Handshake            Carries
//   in_ch_i    in   valid/ready          header, data byte or clear word
//   out_ch_o   out  valid/ready          status, store write, message completion
//   APB        in   psel/penable/pready  buffer_capacity at byte address 0
//
// One word per cycle sustained while the output does not stall; an accepted word enters
// the queue, is loaded into the result register when popped, and is then offered.
// The per-word state update in the back end is combinational, so it sets the rate.
// Reset needs no clearing pass. While the output is stalled the two-entry queue takes
// words until it holds two, and then input ready drops.
module websocket_text_reassembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wstr_in_if.sink                     in_ch_i,
  wstr_out_if.source                  out_ch_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wstr_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wstr_pkg::*;

  logic            push;
  logic            full;
  logic            pop;
  item_t           item;
  q_head_t         head;
  logic [CfgW-1:0] capacity_q, capacity_d;

  // Configuration register.
  assign pready = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && pready && (paddr[2] == RegCapacity)) begin
      capacity_d = pwdata[CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata = (paddr[2] == RegCapacity) ? 32'(capacity_q) : 32'd0;

  wstr_front u_front (
    .in_ch_i (in_ch_i),
    .full_i  (full),
    .push_o  (push),
    .item_o  (item)
  );

  wstr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  wstr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .capacity_i (capacity_q),
    .out_ch_o   (out_ch_o)
  );

endmodule

// ===== rtl/wstr_checker.sv =====
// Port-level checker for the reassembler and its bind to the top level.
`include "assert_macros.svh"

module wstr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic        write_valid_i,
  input logic [11:0] write_address_i,
  input logic [7:0]  write_data_i,
  input logic        message_done_i,
  input logic [12:0] msg_len_i
);
  import wstr_pkg::*;

  logic [36:0] payload;

  // The whole result payload, for the stability check.
  assign payload = {status_i, write_valid_i, write_address_i, write_data_i, message_done_i,
                    msg_len_i};

  // A stalled result word keeps its payload.
  `WSTR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(payload))

  // Without a store write the address and data read as zero.
  `WSTR_ASSERT_IMP(a_write_zero, out_valid_i && !write_valid_i, {write_address_i, write_data_i} == '0)

  // Without a completion the length reads as zero.
  `WSTR_ASSERT_IMP(a_len_zero, out_valid_i && !message_done_i, msg_len_i == 13'd0)

  // A word that carries an error status never writes or completes a message.
  `WSTR_ASSERT_IMP(a_err_quiet, out_valid_i && (status_i != ST_OK), !write_valid_i && !message_done_i)

endmodule

bind websocket_text_reassembler wstr_checker u_wstr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_ch_o.valid),
  .out_ready_i     (out_ch_o.ready),
  .status_i        (out_ch_o.status),
  .write_valid_i   (out_ch_o.write_valid),
  .write_address_i (out_ch_o.write_address),
  .write_data_i    (out_ch_o.write_data),
  .message_done_i  (out_ch_o.message_done),
  .msg_len_i       (out_ch_o.msg_len)
);

// ===== test/websocket_text_reassembler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the WebSocket text reassembler: directed table, random frames.
module websocket_text_reassembler_tb;
  import wstr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseWords = 194;
  localparam int unsigned DirRows    = 25;
  localparam int unsigned Phases     = 8;

  // Codes the block does not define, used to hit its rejection paths.
  localparam logic [1:0] KindUnused   = 2'd3;
  localparam logic [3:0] OpReserved7  = 4'd7;
  localparam logic [3:0] OpReserved15 = 4'd15;

  typedef enum logic [1:0] {
    PaceFull,
    PaceMostly,
    PaceSparse,
    PaceHold
  } pace_e;

  // One input word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic        fin;
    logic [31:0] flen;
    logic [31:0] off;
    logic [31:0] clen;
    logic [7:0]  dbyte;
  } word_t;

  // One result word.
  typedef struct packed {
    status_e            status;
    logic               wr_valid;
    logic [WrAddrW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               done;
    logic [MsgLenW-1:0] len;
  } result_t;

  // A directed row; fixed rows carry a status with all other fields zero.
  typedef struct packed {
    word_t   w;
    logic    fixed;
    status_e st;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  wstr_in_if  in_ch ();
  wstr_out_if out_ch ();

  websocket_text_reassembler u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Model state of the reassembler.
  logic [CfgW-1:0]    cap_reg;
  status_e            err_q;
  logic               msg_open;
  logic               frm_open;
  logic [MsgLenW-1:0] msg_bytes;
  logic [31:0]        frm_total;
  logic [31:0]        frm_done;
  logic [3:0]         frm_op;
  logic               frm_fin;
  logic [31:0]        chunk_left;
  logic               chunk_ctrl;

  result_t     results_due [$];
  word_t       word_backlog [$];
  row_t        dir_tab [DirRows];
  int unsigned mismatches  = 0;
  int unsigned live_words  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  pace_e       pace_mode   = PaceFull;
  int unsigned pace_span   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // An error drops all message, frame and chunk progress and latches its code.
  function automatic void latch_fault(input status_e code);
    err_q      = code;
    msg_open   = 1'b0;
    frm_open   = 1'b0;
    msg_bytes  = '0;
    frm_total  = '0;
    frm_done   = '0;
    chunk_left = '0;
    chunk_ctrl = 1'b0;
  endfunction

  function automatic void reset_conn();
    latch_fault(ST_OK);
    frm_op  = OP_CONT;
    frm_fin = 1'b0;
  endfunction

  // End of a data chunk: closes the frame when it is whole, the message when FIN was set.
  function automatic void finish_chunk(inout result_t r);
    if (chunk_ctrl || frm_done != frm_total) return;
    frm_open = 1'b0;
    if (!frm_fin) return;
    r.done    = 1'b1;
    r.len     = msg_bytes;
    msg_open  = 1'b0;
    msg_bytes = '0;
    frm_total = '0;
    frm_done  = '0;
  endfunction

  // Expected result of one accepted word; advances the model state.
  function automatic result_t reassemble_step(input word_t w);
    result_t     r;
    logic [31:0] cap;
    logic [31:0] room;
    logic        go;
    r    = '0;
    go   = 1'b1;
    cap  = (32'(cap_reg) > 32'(MaxMessageBytes)) ? 32'(MaxMessageBytes) : 32'(cap_reg);
    room = (cap > 32'(msg_bytes)) ? cap - 32'(msg_bytes) : 32'd0;
    if (w.kind == KIND_CLEAR) begin
      reset_conn();
    end else if (err_q == ST_OK && w.kind == KIND_HEADER) begin
      if (chunk_left != 32'd0) begin
        latch_fault(ST_INVALID);
      end else if (w.opcode == OP_CLOSE || w.opcode == OP_PING || w.opcode == OP_PONG) begin
        // Control frames must arrive whole, final and short.
        if (!w.fin || w.flen > 32'(ControlMaxBytes) || w.off != 32'd0 || w.clen != w.flen) begin
          latch_fault(ST_INVALID);
        end else begin
          chunk_left = w.clen;
          chunk_ctrl = 1'b1;
        end
      end else begin
        if (w.off == 32'd0) begin
          // First chunk of a frame.
          if (frm_open) begin
            latch_fault(ST_INVALID);
            go = 1'b0;
          end else if (w.opcode == OP_TEXT) begin
            if (msg_open) begin
              latch_fault(ST_INVALID);
              go = 1'b0;
            end else begin
              msg_open  = 1'b1;
              msg_bytes = '0;
            end
          end else if (w.opcode == OP_CONT) begin
            if (!msg_open) begin
              latch_fault(ST_INVALID);
              go = 1'b0;
            end
          end else begin
            latch_fault(ST_UNSUPPORTED);
            go = 1'b0;
          end
          if (go) begin
            frm_open  = 1'b1;
            frm_total = w.flen;
            frm_done  = '0;
            frm_op    = w.opcode;
            frm_fin   = w.fin;
          end
        end else if (!frm_open || w.opcode != frm_op || w.fin != frm_fin ||
                     w.flen != frm_total) begin
          latch_fault(ST_INVALID);
          go = 1'b0;
        end
        if (go) begin
          // Room is recomputed after a text header reset the message count.
          room = (cap > 32'(msg_bytes)) ? cap - 32'(msg_bytes) : 32'd0;
          if (w.off != frm_done || w.clen > frm_total - frm_done) begin
            latch_fault(ST_INVALID);
          end else if (w.clen > room) begin
            latch_fault(ST_LIMIT);
          end else begin
            frm_done   = frm_done + w.clen;
            chunk_left = w.clen;
            chunk_ctrl = 1'b0;
            if (w.clen == 32'd0) finish_chunk(r);
          end
        end
      end
    end else if (err_q == ST_OK && w.kind == KIND_DATA) begin
      if (chunk_left == 32'd0) begin
        latch_fault(ST_INVALID);
      end else begin
        chunk_left = chunk_left - 32'd1;
        if (!chunk_ctrl) begin
          r.wr_valid = 1'b1;
          r.wr_addr  = msg_bytes[WrAddrW-1:0];
          r.wr_data  = w.dbyte;
          msg_bytes  = msg_bytes + 1'b1;
        end
        if (chunk_left == 32'd0) finish_chunk(r);
      end
    end
    r.status = err_q;
    return r;
  endfunction

  function automatic word_t mk_word(input logic [1:0] kind, input logic [3:0] op,
                                    input logic fin, input logic [31:0] flen,
                                    input logic [31:0] off, input logic [31:0] clen,
                                    input logic [7:0] dbyte);
    word_t w;
    w.kind   = kind;
    w.opcode = op;
    w.fin    = fin;
    w.flen   = flen;
    w.off    = off;
    w.clen   = clen;
    w.dbyte  = dbyte;
    return w;
  endfunction

  function automatic row_t dir_row(input logic [1:0] kind, input logic [3:0] op,
                                   input logic fin, input logic [31:0] flen,
                                   input logic [31:0] off, input logic [31:0] clen,
                                   input logic [7:0] dbyte, input logic fixed,
                                   input status_e st);
    row_t r;
    r.w     = mk_word(kind, op, fin, flen, off, clen, dbyte);
    r.fixed = fixed;
    r.st    = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Present one word, wait for its handshake, record its expected result, then maybe pause.
  task automatic send_word(input word_t w, input logic fixed, input status_e st);
    result_t     r;
    int unsigned gap;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= w.kind;
    in_ch.opcode       <= w.opcode;
    in_ch.fin          <= w.fin;
    in_ch.frame_len    <= w.flen;
    in_ch.chunk_offset <= w.off;
    in_ch.chunk_length <= w.clen;
    in_ch.data_byte    <= w.dbyte;
    do @(posedge clk_i); while (!in_ch.ready);
    // Every accepted word counts toward the phase target.
    live_words++;
    r = reassemble_step(w);
    if (fixed) begin
      r        = '0;
      r.status = st;
    end
    results_due.push_back(r);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic park_sender();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_results(input int unsigned settle);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // APB write of the capacity register: setup cycle, then access cycle.
  task automatic write_capacity(input logic [CfgW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegCapacity, 2'b00};
    pwdata  <= {19'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = value;
  endtask

  // Queue one text message as chunked frames, with an occasional control frame between chunks.
  // Now and then a field is corrupted, noise is sent, or a latched error is cleared.
  task automatic queue_message();
    word_t       m [$];
    int unsigned frames;
    int unsigned flen;
    int unsigned off;
    int unsigned clen;
    int unsigned k;
    int unsigned n;
    logic [3:0]  op;
    if (err_q != ST_OK && $urandom_range(0, 9) != 0) begin
      word_backlog.push_back(mk_word(KIND_CLEAR, OP_CONT, 1'b0, '0, '0, '0, 8'h00));
      return;
    end
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        word_backlog.push_back(mk_word(2'($urandom_range(0, 3)), 4'($urandom),
                                       1'($urandom), $urandom, $urandom, $urandom,
                                       8'($urandom)));
      end
      return;
    end
    frames = $urandom_range(1, 3);
    for (int unsigned f = 0; f < frames; f++) begin
      k = $urandom_range(0, 99);
      if (k < 80) flen = $urandom_range(0, 20);
      else if (k < 97) flen = $urandom_range(21, 160);
      else flen = $urandom_range(161, 700);
      op  = (f == 0) ? OP_TEXT : OP_CONT;
      off = 0;
      do begin
        if (flen == off || $urandom_range(0, 7) == 0) clen = 0;
        else clen = $urandom_range(1, flen - off);
        m.push_back(mk_word(KIND_HEADER, op, 1'(f == frames - 1), flen, off, clen,
                            8'($urandom)));
        repeat (clen) m.push_back(mk_word(KIND_DATA, OP_CONT, 1'b0, '0, '0, '0, 8'($urandom)));
        off += clen;
        // A control frame may slip in between chunks.
        if ($urandom_range(0, 7) == 0) begin
          n = ($urandom_range(0, 15) == 0) ? ControlMaxBytes : $urandom_range(0, 10);
          m.push_back(mk_word(KIND_HEADER, OP_CLOSE + 4'($urandom_range(0, 2)), 1'b1,
                              n, '0, n, 8'h00));
          repeat (n) m.push_back(mk_word(KIND_DATA, OP_CONT, 1'b0, '0, '0, '0, 8'($urandom)));
        end
      end while (off < flen);
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, m.size() - 1);
      case ($urandom_range(0, 5))
        0: m[k].opcode = 4'($urandom);
        1: m[k].fin = ~m[k].fin;
        2: m[k].flen = $urandom;
        3: m[k].off = $urandom;
        4: m[k].clen = $urandom;
        default: m[k].kind = 2'($urandom_range(1, 3));
      endcase
    end
    foreach (m[i]) word_backlog.push_back(m[i]);
  endtask

  // Receiver readiness follows spans of random length, each with its own pattern.
  always @(posedge clk_i) begin : sink_pace
    if (pace_span == 0) begin
      pace_mode <= pace_e'($urandom_range(0, 3));
      pace_span <= $urandom_range(1, 48);
    end else begin
      pace_span <= pace_span - 1;
    end
    case (pace_mode)
      PaceFull:   out_ch.ready <= 1'b1;
      PaceMostly: out_ch.ready <= ($urandom_range(0, 3) != 0);
      PaceSparse: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:    out_ch.ready <= 1'b0;
    endcase
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("write_valid", 32'(want.wr_valid), 32'(out_ch.write_valid));
        check_field("write_address", 32'(want.wr_addr), 32'(out_ch.write_address));
        check_field("write_data", 32'(want.wr_data), 32'(out_ch.write_data));
        check_field("message_done", 32'(want.done), 32'(out_ch.message_done));
        check_field("msg_len", 32'(want.len), 32'(out_ch.msg_len));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[websocket_text_reassembler] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CfgW-1:0] caps [Phases];
    int unsigned     target;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_CLEAR;
    in_ch.opcode       = OP_CONT;
    in_ch.fin          = 1'b0;
    in_ch.frame_len    = '0;
    in_ch.chunk_offset = '0;
    in_ch.chunk_length = '0;
    in_ch.data_byte    = '0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cap_reg            = CapacityReset;
    reset_conn();

    // Capacity settings: reset value, the smallest nonzero, saturation, zero and a few in between.
    caps = '{CfgW'(4096), CfgW'(1), CfgW'(8191), CfgW'(0), CfgW'(300),
             CfgW'($urandom_range(2, 4095)), CfgW'(24), CfgW'(4096)};

    // Directed table; fixed rows hold the status that is plain from the rules.
    dir_tab[0]  = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Stray byte, then a word ignored while the error is latched.
    dir_tab[1]  = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'hFF, 1'b1,
                          ST_INVALID);
    dir_tab[2]  = dir_row(KIND_HEADER, OP_TEXT, 1'b1, 32'd1, 32'd0, 32'd1, 8'h00, 1'b1,
                          ST_INVALID);
    dir_tab[3]  = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Unsupported opcode at offset zero, then the unused kind repeats the status.
    dir_tab[4]  = dir_row(KIND_HEADER, OpReserved15, 1'b1, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1,
                          ST_UNSUPPORTED);
    dir_tab[5]  = dir_row(KindUnused, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1,
                          ST_UNSUPPORTED);
    dir_tab[6]  = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Largest frame and chunk overflow the store.
    dir_tab[7]  = dir_row(KIND_HEADER, OP_TEXT, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                          8'h00, 1'b1, ST_LIMIT);
    dir_tab[8]  = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Ping with two dropped bytes.
    dir_tab[9]  = dir_row(KIND_HEADER, OP_PING, 1'b1, 32'd2, 32'd0, 32'd2, 8'h00, 1'b0, ST_OK);
    dir_tab[10] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b0, ST_OK);
    dir_tab[11] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'hFF, 1'b0, ST_OK);
    // Text frame in two chunks, then an empty final continuation completes the message.
    dir_tab[12] = dir_row(KIND_HEADER, OP_TEXT, 1'b0, 32'd3, 32'd0, 32'd2, 8'h00, 1'b0, ST_OK);
    dir_tab[13] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b0, ST_OK);
    dir_tab[14] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'hFF, 1'b0, ST_OK);
    dir_tab[15] = dir_row(KIND_HEADER, OP_TEXT, 1'b0, 32'd3, 32'd2, 32'd1, 8'h00, 1'b0, ST_OK);
    dir_tab[16] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h41, 1'b0, ST_OK);
    dir_tab[17] = dir_row(KIND_HEADER, OP_CONT, 1'b1, 32'd0, 32'd0, 32'd0, 8'h00, 1'b0, ST_OK);
    // Later chunk with no frame open.
    dir_tab[18] = dir_row(KIND_HEADER, OP_CONT, 1'b1, 32'd5, 32'hFFFF_FFFF, 32'd0, 8'h00,
                          1'b1, ST_INVALID);
    dir_tab[19] = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Header while a chunk still has bytes pending.
    dir_tab[20] = dir_row(KIND_HEADER, OP_TEXT, 1'b1, 32'd4, 32'd0, 32'd2, 8'h00, 1'b0, ST_OK);
    dir_tab[21] = dir_row(KIND_DATA, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h5A, 1'b0, ST_OK);
    dir_tab[22] = dir_row(KIND_HEADER, OP_TEXT, 1'b1, 32'd4, 32'd2, 32'd2, 8'h00, 1'b1,
                          ST_INVALID);
    dir_tab[23] = dir_row(KIND_CLEAR, OP_CONT, 1'b0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1, ST_OK);
    // Unsupported opcode at a nonzero offset fails the metadata match.
    dir_tab[24] = dir_row(KIND_HEADER, OpReserved7, 1'b0, 32'd1, 32'd1, 32'd0, 8'h00, 1'b1,
                          ST_INVALID);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].st);
    park_sender();

    // Random phases; message state carries over a capacity change on purpose.
    for (int unsigned ph = 0; ph < Phases; ph++) begin
      drain_results(4);
      write_capacity(caps[ph]);
      target = live_words + PhaseWords;
      while (live_words < target) begin
        if (word_backlog.size() == 0) queue_message();
        send_word(word_backlog.pop_front(), 1'b0, ST_OK);
      end
      park_sender();
    end

    drain_results(8);
    if (mismatches == 0) begin
      $display("[websocket_text_reassembler] OK");
    end else begin
      $display("[websocket_text_reassembler] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wstr_pkg.sv
rtl/wstr_if.sv
rtl/wstr_front.sv
rtl/wstr_queue.sv
rtl/wstr_back.sv
rtl/websocket_text_reassembler.sv
rtl/wstr_checker.sv
test/websocket_text_reassembler_tb.sv
